// ===== design/lirs_pkg.sv =====
// shared constants, types and controller/datapath interface for the resampler
package lirs_pkg;

    localparam int COUNT_WIDTH  = 32;
    localparam int MAX_UPSAMPLE = 32;
    localparam int MAX_RESULTS  = 64;

    localparam int SAMPLE_W  = 16;
    localparam int RATE_W    = 19;
    localparam int CFG_IDX_W = 1;
    localparam int NCNT_W    = $clog2(MAX_RESULTS + 1);

    localparam logic [CFG_IDX_W-1:0] REG_IN_RATE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_RATE = 1'd1;

    localparam logic [RATE_W-1:0] IN_RATE_RST  = 19'd48000;
    localparam logic [RATE_W-1:0] OUT_RATE_RST = 19'd16000;

    // shared restoring divider: quotient must fit DIV_Q_W bits
    localparam int DIV_DVD_W = 37;
    localparam int DIV_DVS_W = 20;
    localparam int DIV_Q_W   = 19;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W);
    localparam int DIV_SH_W  = DIV_DVS_W + DIV_Q_W - 1;

    typedef enum logic [1:0] {
        ESEL_PEND,
        ESEL_INTERP,
        ESEL_HELD
    } t_esel;

    typedef enum logic [1:0] {
        DSEL_IN_OVER_OUT,
        DSEL_OUT_OVER_IN,
        DSEL_INTERP
    } t_dsel;

    typedef struct packed {
        logic  load;
        logic  count;
        logic  emit;
        t_esel emit_sel;
        logic  pend_store;
        logic  mul;
        logic  div_start;
        t_dsel div_sel;
        logic  store_step;
        logic  store_bnd_step;
        logic  adv;
        logic  skip_dec;
        logic  hold;
        logic  flush;
        logic  err_out;
    } t_cmd;

    typedef struct packed {
        logic step_ok;
        logic rate_err;
        logic pend_valid;
        logic om_lt_bound;
        logic idx_lt_bound;
        logic have_held;
        logic skip_zero;
        logic last;
        logic emit_ok;
        logic stg_valid;
        logic out_free;
        logic n_lt_max;
        logic div_done;
        logic cfg_hit;
    } t_sts;

endpackage

// ===== design/linear_interp_resampler.sv =====
// top level: linear interpolation sample rate converter
// one request at a time: accept, check, pending result, then per output computed loop,
// multiply, the 19-step shared divider and emit, or a phase step for a dropped output;
// at stream end tail copies of the held sample follow; a rate error gives an error result
// output stalls hold the flow; synchronous active-low reset: rates 48000/16000, stream cleared;
// after reset and after every rate write two divisions set up step constants before input is taken
module linear_interp_resampler #(
    parameter int COUNT_WIDTH  = lirs_pkg::COUNT_WIDTH,
    parameter int MAX_UPSAMPLE = lirs_pkg::MAX_UPSAMPLE
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                 i_stream_end,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [lirs_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                 o_run_last,
    output logic                                 o_stream_done,
    output logic                                 o_rate_error,
    input  logic                                 i_cfg_we,
    input  logic [lirs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [lirs_pkg::RATE_W-1:0]          i_cfg_data
);

    lirs_pkg::t_cmd w_cmd;
    lirs_pkg::t_sts w_sts;

    lirs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lirs_dp #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .MAX_UPSAMPLE (MAX_UPSAMPLE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_sample_in   (i_sample_in),
        .i_stream_end  (i_stream_end),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_sample_out  (o_sample_out),
        .o_run_last    (o_run_last),
        .o_stream_done (o_stream_done),
        .o_rate_error  (o_rate_error)
    );

endmodule

// ===== design/lirs_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module lirs_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [lirs_pkg::DIV_DVD_W-1:0]      i_dividend,
    input  logic [lirs_pkg::DIV_DVS_W-1:0]      i_divisor,
    output logic                                o_done,
    output logic [lirs_pkg::DIV_Q_W-1:0]        o_quo,
    output logic [lirs_pkg::DIV_DVD_W-1:0]      o_rem
);

    localparam int DW = lirs_pkg::DIV_DVD_W;
    localparam int QW = lirs_pkg::DIV_Q_W;
    localparam int SW = lirs_pkg::DIV_SH_W;
    localparam int CW = lirs_pkg::DIV_CNT_W;

    logic [DW-1:0] r_rem;
    logic [SW-1:0] r_ds;
    logic [QW-1:0] r_quo;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic          w_ge;
    logic [SW-1:0] w_diff;

    assign w_ge   = SW'(r_rem) >= r_ds;
    assign w_diff = SW'(r_rem) - r_ds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_ds  <= {i_divisor, (QW - 1)'(0)};
            r_quo <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= w_diff[DW-1:0];
            end
            r_quo <= {r_quo[QW-2:0], w_ge};
            r_ds  <= r_ds >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== design/lirs_ctrl.sv =====
// sequencing state machine for the resampler
module lirs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  lirs_pkg::t_sts i_sts,
    output lirs_pkg::t_cmd o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_CW0   = 13'b0000000000010,
        S_CW1   = 13'b0000000000100,
        S_CHECK = 13'b0000000001000,
        S_ERR   = 13'b0000000010000,
        S_PEND  = 13'b0000000100000,
        S_LOOP  = 13'b0000001000000,
        S_MUL   = 13'b0000010000000,
        S_IWAIT = 13'b0000100000000,
        S_IOUT  = 13'b0001000000000,
        S_HOLD  = 13'b0010000000000,
        S_TAIL  = 13'b0100000000000,
        S_FLUSH = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_ready;

    assign w_ready    = (r_state == S_IDLE) && i_sts.step_ok && !i_sts.cfg_hit;
    assign o_in_stall = !w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                priority if (i_sts.cfg_hit) begin
                    n_state = S_IDLE;
                end else if (!i_sts.step_ok) begin
                    // rate change: work out the per-sample step constants
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = lirs_pkg::DSEL_IN_OVER_OUT;
                    n_state         = S_CW0;
                end else if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CW0: begin
                priority if (i_sts.cfg_hit) begin
                    n_state = S_IDLE;
                end else if (i_sts.div_done) begin
                    o_cmd.store_step = 1'b1;
                    o_cmd.div_start  = 1'b1;
                    o_cmd.div_sel    = lirs_pkg::DSEL_OUT_OVER_IN;
                    n_state          = S_CW1;
                end
            end
            S_CW1: begin
                priority if (i_sts.cfg_hit) begin
                    n_state = S_IDLE;
                end else if (i_sts.div_done) begin
                    o_cmd.store_bnd_step = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            S_CHECK: begin
                if (i_sts.rate_err) begin
                    n_state = S_ERR;
                end else begin
                    o_cmd.count = 1'b1;
                    n_state     = S_PEND;
                end
            end
            S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.err_out = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_PEND: begin
                priority if (i_sts.pend_valid && i_sts.om_lt_bound) begin
                    if (i_sts.emit_ok) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = lirs_pkg::ESEL_PEND;
                        n_state        = S_LOOP;
                    end
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                priority if (!i_sts.have_held) begin
                    n_state = S_HOLD;
                end else if (!i_sts.skip_zero) begin
                    o_cmd.skip_dec = 1'b1;
                    n_state        = S_HOLD;
                end else if (i_sts.idx_lt_bound || (!i_sts.last && !i_sts.pend_valid)) begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_MUL;
                end else begin
                    // result would be dropped: just step the phase
                    o_cmd.adv = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = lirs_pkg::DSEL_INTERP;
                n_state         = S_IWAIT;
            end
            S_IWAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_IOUT;
                end
            end
            S_IOUT: begin
                priority if (i_sts.idx_lt_bound) begin
                    if (i_sts.emit_ok) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = lirs_pkg::ESEL_INTERP;
                        o_cmd.adv      = 1'b1;
                        n_state        = S_LOOP;
                    end
                end else begin
                    o_cmd.pend_store = !i_sts.last && !i_sts.pend_valid;
                    o_cmd.adv        = 1'b1;
                    n_state          = S_LOOP;
                end
            end
            S_HOLD: begin
                o_cmd.hold = 1'b1;
                n_state    = i_sts.last ? S_TAIL : S_FLUSH;
            end
            S_TAIL: begin
                priority if (i_sts.om_lt_bound && i_sts.n_lt_max) begin
                    if (i_sts.emit_ok) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = lirs_pkg::ESEL_HELD;
                    end
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!i_sts.stg_valid || i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/lirs_dp.sv =====
// datapath: rate registers, stream state, interpolation and result registers
module lirs_dp #(
    parameter int COUNT_WIDTH  = lirs_pkg::COUNT_WIDTH,
    parameter int MAX_UPSAMPLE = lirs_pkg::MAX_UPSAMPLE
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lirs_pkg::t_cmd                       i_cmd,
    output lirs_pkg::t_sts                       o_sts,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                 i_stream_end,
    input  logic                                 i_cfg_we,
    input  logic [lirs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [lirs_pkg::RATE_W-1:0]          i_cfg_data,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic signed [lirs_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                 o_run_last,
    output logic                                 o_stream_done,
    output logic                                 o_rate_error
);

    localparam int SW   = lirs_pkg::SAMPLE_W;
    localparam int RW   = lirs_pkg::RATE_W;
    localparam int CW   = COUNT_WIDTH;
    localparam int QSW  = COUNT_WIDTH + RW + 1;
    localparam int UPW  = RW + 6;
    localparam int NW   = lirs_pkg::NCNT_W;
    localparam int DVDW = lirs_pkg::DIV_DVD_W;
    localparam int DVSW = lirs_pkg::DIV_DVS_W;
    localparam int QW   = lirs_pkg::DIV_Q_W;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    // configuration and step constants
    logic [RW-1:0] r_in_rate, r_out_rate;
    logic          r_step_ok;
    logic [QW-1:0] r_sq, r_bq;
    logic [RW-1:0] r_sr, r_br;

    // current item
    logic signed [SW-1:0] r_x;
    logic                 r_last;
    logic [NW-1:0]        r_nres;

    // stream state
    logic signed [SW-1:0] r_held;
    logic                 r_have_held;
    logic [RW-1:0]        r_phase, r_skip;
    logic [CW-1:0]        r_in_seen, r_out_made, r_bnd_q;
    logic [RW+1:0]        r_bnd_r;
    logic                 r_pend_valid;
    logic signed [SW-1:0] r_pend_val;

    // interpolation product and divider sign
    logic signed [36:0] r_prod;
    logic               r_nneg;

    // staging and output registers
    logic                 r_stg_valid;
    logic signed [SW-1:0] r_stg_val;
    logic                 r_out_valid;
    logic signed [SW-1:0] r_out_sample;
    logic                 r_out_run_last, r_out_done, r_out_err;

    // divider
    logic              w_div_done;
    logic [QW-1:0]     w_quo;
    logic [DVDW-1:0]   w_rem;
    logic [DVDW-1:0]   w_dvd;
    logic [DVSW-1:0]   w_dvs;

    logic                 w_cfg_hit, w_clr, w_out_free, w_n_lt_max, w_rate_err;
    logic [UPW-1:0]       w_up;
    logic [RW-1:0]        w_new_ir;
    logic signed [16:0]   w_diff;
    logic signed [19:0]   w_ph;
    logic signed [36:0]   w_prod;
    logic signed [37:0]   w_num, w_num_neg;
    logic [DVDW-1:0]      w_num_abs;
    logic [19:0]          w_quo_ext;
    logic signed [19:0]   w_qs, w_y;
    logic signed [SW-1:0] w_emit_val;
    logic [RW:0]          w_psum;
    logic                 w_wrap;
    logic [RW:0]          w_skip_sum;
    logic [RW+1:0]        w_bsum, w_two_ir;
    logic                 w_bnd_c;
    logic [QSW-1:0]       w_bq_sum;
    logic [CW-1:0]        w_bq_next;
    logic [CW:0]          w_idx;

    assign w_cfg_hit  = i_cfg_we
                        && (i_cfg_idx == lirs_pkg::REG_IN_RATE
                            || i_cfg_idx == lirs_pkg::REG_OUT_RATE);
    assign w_new_ir   = (w_cfg_hit && i_cfg_idx == lirs_pkg::REG_IN_RATE)
                        ? i_cfg_data : r_in_rate;
    assign w_clr      = w_cfg_hit || ((i_cmd.flush || i_cmd.err_out) && r_last);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_n_lt_max = r_nres < NW'(lirs_pkg::MAX_RESULTS);

    assign w_up       = UPW'(r_in_rate) * UPW'(MAX_UPSAMPLE);
    assign w_rate_err = (r_in_rate == '0) || (r_out_rate == '0)
                        || (UPW'(r_out_rate) > w_up);

    // (b - a) * phase, then 2*t + out_rate for round-half-up
    assign w_diff    = 17'(r_x) - 17'(r_held);
    assign w_ph      = $signed({1'b0, r_phase});
    assign w_prod    = w_diff * w_ph;
    assign w_num     = (38'(r_prod) <<< 1) + 38'($signed({1'b0, r_out_rate}));
    assign w_num_neg = -w_num;
    assign w_num_abs = w_num[37] ? w_num_neg[DVDW-1:0] : w_num[DVDW-1:0];

    // floor division for both signs
    assign w_quo_ext = 20'(w_quo);
    assign w_qs      = r_nneg ? $signed(w_quo_ext)
                              : -$signed(w_quo_ext + 20'(w_rem != '0));
    assign w_y       = 20'(r_held) + w_qs;

    always_comb begin
        unique case (i_cmd.emit_sel)
            lirs_pkg::ESEL_PEND:   w_emit_val = r_pend_val;
            lirs_pkg::ESEL_INTERP: w_emit_val = w_y[SW-1:0];
            lirs_pkg::ESEL_HELD:   w_emit_val = r_held;
            default:               w_emit_val = r_held;
        endcase
    end

    always_comb begin
        unique case (i_cmd.div_sel)
            lirs_pkg::DSEL_IN_OVER_OUT: begin
                w_dvd = DVDW'(r_in_rate);
                w_dvs = DVSW'(r_out_rate);
            end
            lirs_pkg::DSEL_OUT_OVER_IN: begin
                w_dvd = DVDW'(r_out_rate);
                w_dvs = DVSW'(r_in_rate);
            end
            lirs_pkg::DSEL_INTERP: begin
                w_dvd = w_num_abs;
                w_dvs = {r_out_rate, 1'b0};
            end
            default: begin
                w_dvd = w_num_abs;
                w_dvs = {r_out_rate, 1'b0};
            end
        endcase
    end

    lirs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    // phase steps by in_rate mod out_rate, skip by the quotient plus wrap
    assign w_psum     = {1'b0, r_phase} + {1'b0, r_sr};
    assign w_wrap     = w_psum >= {1'b0, r_out_rate};
    assign w_skip_sum = {1'b0, r_skip} + (RW + 1)'(r_sq) + (RW + 1)'(w_wrap);

    // running round(n*out/in): quotient and remainder by 2*in_rate
    assign w_bsum    = r_bnd_r + {1'b0, r_br, 1'b0};
    assign w_two_ir  = {1'b0, r_in_rate, 1'b0};
    assign w_bnd_c   = w_bsum >= w_two_ir;
    assign w_bq_sum  = QSW'(r_bnd_q) + QSW'(r_bq) + QSW'(w_bnd_c);
    assign w_bq_next = (w_bq_sum > QSW'(CNT_MAX)) ? CNT_MAX : w_bq_sum[CW-1:0];

    assign w_idx = {1'b0, r_out_made} + (CW + 1)'(r_pend_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_rate    <= lirs_pkg::IN_RATE_RST;
            r_out_rate   <= lirs_pkg::OUT_RATE_RST;
            r_step_ok    <= 1'b0;
            r_last       <= 1'b0;
            r_nres       <= '0;
            r_held       <= '0;
            r_have_held  <= 1'b0;
            r_phase      <= '0;
            r_skip       <= '0;
            r_in_seen    <= '0;
            r_out_made   <= '0;
            r_bnd_q      <= '0;
            r_bnd_r      <= (RW + 2)'(lirs_pkg::IN_RATE_RST);
            r_pend_valid <= 1'b0;
            r_stg_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_cfg_hit) begin
                if (i_cfg_idx == lirs_pkg::REG_IN_RATE) begin
                    r_in_rate <= i_cfg_data;
                end else begin
                    r_out_rate <= i_cfg_data;
                end
            end

            if (i_cmd.store_bnd_step) begin
                r_step_ok <= 1'b1;
            end
            if (w_cfg_hit) begin
                r_step_ok <= 1'b0;
            end

            if (i_cmd.load) begin
                r_last <= i_stream_end;
                r_nres <= '0;
            end

            if (i_cmd.count && r_in_seen != CNT_MAX) begin
                r_in_seen <= r_in_seen + CW'(1);
                r_bnd_q   <= w_bq_next;
                r_bnd_r   <= w_bnd_c ? (w_bsum - w_two_ir) : w_bsum;
            end

            if (i_cmd.adv) begin
                r_phase <= w_wrap ? RW'(w_psum - {1'b0, r_out_rate}) : w_psum[RW-1:0];
                r_skip  <= w_skip_sum[RW-1:0];
            end
            if (i_cmd.skip_dec) begin
                r_skip <= r_skip - RW'(1);
            end

            if (i_cmd.hold) begin
                r_have_held <= 1'b1;
                r_held      <= r_x;
            end

            if (i_cmd.pend_store) begin
                r_pend_valid <= 1'b1;
            end

            if (i_cmd.emit) begin
                if (r_out_made != CNT_MAX) begin
                    r_out_made <= r_out_made + CW'(1);
                end
                if (i_cmd.emit_sel == lirs_pkg::ESEL_PEND) begin
                    r_pend_valid <= 1'b0;
                end
                if (w_n_lt_max) begin
                    r_nres      <= r_nres + NW'(1);
                    r_stg_valid <= 1'b1;
                end
            end
            if (i_cmd.flush) begin
                r_stg_valid <= 1'b0;
            end

            // output register: loaded only when empty or being taken
            if (i_cmd.emit && w_n_lt_max && r_stg_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_cmd.flush && r_stg_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_cmd.err_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // end of stream or a rate write restarts the stream
            if (w_clr) begin
                r_held       <= '0;
                r_have_held  <= 1'b0;
                r_phase      <= '0;
                r_skip       <= '0;
                r_in_seen    <= '0;
                r_out_made   <= '0;
                r_bnd_q      <= '0;
                r_bnd_r      <= (RW + 2)'(w_new_ir);
                r_pend_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_step) begin
            r_sq <= w_quo;
            r_sr <= w_rem[RW-1:0];
        end
        if (i_cmd.store_bnd_step) begin
            r_bq <= w_quo;
            r_br <= w_rem[RW-1:0];
        end
        if (i_cmd.load) begin
            r_x <= i_sample_in;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.div_start) begin
            r_nneg <= !w_num[37];
        end
        if (i_cmd.pend_store) begin
            r_pend_val <= w_y[SW-1:0];
        end
        if (i_cmd.emit && w_n_lt_max) begin
            r_stg_val <= w_emit_val;
        end

        if (i_cmd.emit && w_n_lt_max && r_stg_valid) begin
            r_out_sample   <= r_stg_val;
            r_out_run_last <= 1'b0;
            r_out_done     <= 1'b0;
            r_out_err      <= 1'b0;
        end else if (i_cmd.flush && r_stg_valid) begin
            r_out_sample   <= r_stg_val;
            r_out_run_last <= 1'b1;
            r_out_done     <= r_last;
            r_out_err      <= 1'b0;
        end else if (i_cmd.err_out) begin
            r_out_sample   <= '0;
            r_out_run_last <= 1'b1;
            r_out_done     <= r_last;
            r_out_err      <= 1'b1;
        end
    end

    always_comb begin
        o_sts              = '0;
        o_sts.step_ok      = r_step_ok;
        o_sts.rate_err     = w_rate_err;
        o_sts.pend_valid   = r_pend_valid;
        o_sts.om_lt_bound  = r_out_made < r_bnd_q;
        o_sts.idx_lt_bound = w_idx < {1'b0, r_bnd_q};
        o_sts.have_held    = r_have_held;
        o_sts.skip_zero    = r_skip == '0;
        o_sts.last         = r_last;
        o_sts.emit_ok      = !r_stg_valid || w_out_free || !w_n_lt_max;
        o_sts.stg_valid    = r_stg_valid;
        o_sts.out_free     = w_out_free;
        o_sts.n_lt_max     = w_n_lt_max;
        o_sts.div_done     = w_div_done;
        o_sts.cfg_hit      = w_cfg_hit;
    end

    assign o_out_valid   = r_out_valid;
    assign o_sample_out  = r_out_sample;
    assign o_run_last    = r_out_run_last;
    assign o_stream_done = r_out_done;
    assign o_rate_error  = r_out_err;

endmodule

// ===== design/lirs_chk.sv =====
// port-level checker for the resampler, bound to the top level
module lirs_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [lirs_pkg::SAMPLE_W-1:0] o_sample_out,
    input logic                                 o_run_last,
    input logic                                 o_stream_done,
    input logic                                 o_rate_error
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample_out)
            && $stable(o_run_last) && $stable(o_stream_done) && $stable(o_rate_error))
        else $error("stalled result changed");

    // one request in flight: stall rises right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while busy");

    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rate_error |-> o_run_last && o_sample_out == '0)
        else $error("rate error result malformed");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stream_done |-> o_run_last)
        else $error("stream end not on last result of its request");

    // after reset no result is valid and requests stall while step constants are rebuilt
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("block not quiet after reset");

endmodule

bind linear_interp_resampler lirs_chk u_lirs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_sample_out  (o_sample_out),
    .o_run_last    (o_run_last),
    .o_stream_done (o_stream_done),
    .o_rate_error  (o_rate_error)
);
